// ===== rtl/wrp_pkg.sv =====
package wrp_pkg;

  // Four-character chunk tags, first file byte in the top bits
  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TRUNC   = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_UNSUP   = 2'd3;

  // Only PCM is accepted, and only 16-bit samples
  localparam logic [15:0] FORMAT_PCM  = 16'h0001;
  localparam logic [15:0] PCM_WIDTH   = 16'd16;
  localparam logic [4:0]  SAMPLE_BITS = 5'd16;
  // Bytes of a fmt chunk that carry fields
  localparam logic [4:0]  FMT_BYTES   = 5'd16;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 80;

  // One input request
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } wrp_item_t;

  // One result request
  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  channel_count;
    logic [31:0] frame_rate;
    logic [4:0]  sample_bits;
    logic [31:0] data_length;
  } wrp_result_t;

endpackage

// ===== rtl/wrp_in_reg.sv =====
module wrp_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  wrp_pkg::wrp_item_t in_item,
  input  logic              advance,
  output logic              q_valid,
  output wrp_pkg::wrp_item_t q_item
);
  import wrp_pkg::*;

  logic      q_valid_r;
  logic      q_valid_nxt;
  wrp_item_t q_item_r;

  // Take a new request when none is held or the held one moves on this cycle
  assign in_ready = !q_valid_r || advance;

  always_comb begin
    q_valid_nxt = q_valid_r;
    if (in_valid && in_ready) begin
      q_valid_nxt = 1'b1;
    end else if (advance) begin
      q_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_valid_r <= 1'b0;
    end else begin
      q_valid_r <= q_valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_item_r <= in_item;
    end
  end

  assign q_valid = q_valid_r;
  assign q_item  = q_item_r;

endmodule

// ===== rtl/wrp_parser.sv =====
module wrp_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_valid,
  input  wrp_pkg::wrp_item_t  item,
  output logic                res_valid,
  output wrp_pkg::wrp_result_t res
);
  import wrp_pkg::*;

  typedef enum logic [4:0] {
    PH_RIFF = 5'b00001,
    PH_HDR  = 5'b00010,
    PH_FMT  = 5'b00100,
    PH_SKIP = 5'b01000,
    PH_DONE = 5'b10000
  } wrp_phase_t;

  // Field bytes held in a fmt chunk of the given length
  function automatic logic [4:0] fmt_len(input logic [31:0] len);
    fmt_len = (len < {27'd0, FMT_BYTES}) ? len[4:0] : FMT_BYTES;
  endfunction

  wrp_phase_t  phase_r,     phase_nxt;
  logic [4:0]  idx_r,       idx_nxt;
  logic [31:0] tag_r,       tag_nxt;
  logic [31:0] len_r,       len_nxt;
  logic [31:0] skip_r,      skip_nxt;
  logic        hok_r,       hok_nxt;
  logic [15:0] format_r,    format_nxt;
  logic [15:0] chan_r,      chan_nxt;
  logic [31:0] rate_r,      rate_nxt;
  logic [15:0] width_r,     width_nxt;
  logic        fmt_seen_r,  fmt_seen_nxt;
  logic        pad_r,       pad_nxt;

  logic [31:0] tag_sh;
  logic [31:0] len_base;
  logic [4:0]  fmtb;
  logic [3:0]  k;

  always_comb begin
    phase_nxt    = phase_r;
    idx_nxt      = idx_r;
    tag_nxt      = tag_r;
    len_nxt      = len_r;
    skip_nxt     = skip_r;
    hok_nxt      = hok_r;
    format_nxt   = format_r;
    chan_nxt     = chan_r;
    rate_nxt     = rate_r;
    width_nxt    = width_r;
    fmt_seen_nxt = fmt_seen_r;
    pad_nxt      = pad_r;
    res_valid    = 1'b0;
    res          = '0;
    tag_sh       = {tag_r[23:0], item.data_byte};
    len_base     = (idx_r == 5'd0) ? 32'd0 : len_r;
    fmtb         = fmt_len(len_r);
    k            = idx_r[3:0];

    if (item_valid) begin
      if (item.end_of_stream) begin
        // End marker: report where the stream stopped, then rearm
        if (phase_r != PH_DONE) begin
          res_valid = 1'b1;
          case (phase_r)
            PH_RIFF, PH_FMT: res.status = ST_TRUNC;
            PH_HDR:          res.status = (idx_r == 5'd0) ? ST_INVALID : ST_TRUNC;
            default:         res.status = ST_INVALID;
          endcase
        end
        phase_nxt    = PH_RIFF;
        idx_nxt      = 5'd0;
        tag_nxt      = 32'd0;
        len_nxt      = 32'd0;
        skip_nxt     = 32'd0;
        hok_nxt      = 1'b1;
        format_nxt   = 16'd0;
        chan_nxt     = 16'd0;
        rate_nxt     = 32'd0;
        width_nxt    = 16'd0;
        fmt_seen_nxt = 1'b0;
        pad_nxt      = 1'b0;
      end else begin
        case (phase_r)
          // 12-byte RIFF/WAVE file header
          PH_RIFF: begin
            tag_nxt = tag_sh;
            if (idx_r == 5'd3 && tag_sh != TAG_RIFF) begin
              hok_nxt = 1'b0;
            end
            if (idx_r == 5'd11) begin
              hok_nxt = hok_nxt && (tag_sh == TAG_WAVE);
              idx_nxt = 5'd0;
              tag_nxt = 32'd0;
              if (!hok_nxt) begin
                res_valid  = 1'b1;
                res.status = ST_INVALID;
                phase_nxt  = PH_DONE;
              end else begin
                phase_nxt = PH_HDR;
              end
            end else begin
              idx_nxt = idx_r + 5'd1;
            end
          end

          // Chunk header: tag, then little-endian length
          PH_HDR: begin
            if (idx_r < 5'd4) begin
              tag_nxt = tag_sh;
              len_nxt = len_base;
            end else begin
              len_nxt = len_r | ({24'd0, item.data_byte} << {idx_r[1:0], 3'b000});
            end
            if (idx_r < 5'd7) begin
              idx_nxt = idx_r + 5'd1;
            end else begin
              idx_nxt = 5'd0;
              if (tag_nxt == TAG_FMT) begin
                format_nxt = 16'd0;
                chan_nxt   = 16'd0;
                rate_nxt   = 32'd0;
                width_nxt  = 16'd0;
                // Empty fmt chunk reads as format zero
                if (fmt_len(len_nxt) == 5'd0) begin
                  res_valid  = 1'b1;
                  res.status = ST_UNSUP;
                  phase_nxt  = PH_DONE;
                end else begin
                  phase_nxt = PH_FMT;
                end
              end else if (tag_nxt == TAG_DATA) begin
                phase_nxt = PH_DONE;
                res_valid = 1'b1;
                if (!fmt_seen_r) begin
                  res.status = ST_INVALID;
                end else if (rate_r == 32'd0 || width_r != PCM_WIDTH ||
                             (chan_r != 16'd1 && chan_r != 16'd2)) begin
                  res.status = ST_UNSUP;
                end else begin
                  res.status        = ST_OK;
                  res.channel_count = chan_r[1:0];
                  res.frame_rate    = rate_r;
                  res.sample_bits   = SAMPLE_BITS;
                  res.data_length   = len_nxt;
                end
              end else begin
                skip_nxt  = len_nxt;
                pad_nxt   = len_nxt[0];
                phase_nxt = (len_nxt == 32'd0) ? PH_HDR : PH_SKIP;
              end
            end
          end

          // fmt chunk field bytes
          PH_FMT: begin
            if (k < 4'd2) begin
              format_nxt = format_r | ({8'd0, item.data_byte} << {k[0], 3'b000});
            end else if (k < 4'd4) begin
              chan_nxt = chan_r | ({8'd0, item.data_byte} << {k[0], 3'b000});
            end else if (k < 4'd8) begin
              rate_nxt = rate_r | ({24'd0, item.data_byte} << {k[1:0], 3'b000});
            end else if (k >= 4'd14) begin
              width_nxt = width_r | ({8'd0, item.data_byte} << {k[0], 3'b000});
            end
            idx_nxt = {1'b0, k} + 5'd1;
            if (idx_nxt >= fmtb) begin
              if (format_nxt != FORMAT_PCM) begin
                res_valid  = 1'b1;
                res.status = ST_UNSUP;
                phase_nxt  = PH_DONE;
              end else begin
                fmt_seen_nxt = 1'b1;
                skip_nxt     = len_r - {27'd0, fmtb};
                pad_nxt      = len_r[0];
                idx_nxt      = 5'd0;
                phase_nxt    = (skip_nxt == 32'd0 && !pad_nxt) ? PH_HDR : PH_SKIP;
              end
            end
          end

          // Skip chunk body, then the pad byte of an odd length
          PH_SKIP: begin
            if (skip_r != 32'd0) begin
              skip_nxt = skip_r - 32'd1;
            end else begin
              pad_nxt = 1'b0;
            end
            idx_nxt   = 5'd0;
            phase_nxt = (skip_nxt == 32'd0 && !pad_nxt) ? PH_HDR : PH_SKIP;
          end

          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_RIFF;
      idx_r      <= 5'd0;
      tag_r      <= 32'd0;
      len_r      <= 32'd0;
      skip_r     <= 32'd0;
      hok_r      <= 1'b1;
      format_r   <= 16'd0;
      chan_r     <= 16'd0;
      rate_r     <= 32'd0;
      width_r    <= 16'd0;
      fmt_seen_r <= 1'b0;
      pad_r      <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      idx_r      <= idx_nxt;
      tag_r      <= tag_nxt;
      len_r      <= len_nxt;
      skip_r     <= skip_nxt;
      hok_r      <= hok_nxt;
      format_r   <= format_nxt;
      chan_r     <= chan_nxt;
      rate_r     <= rate_nxt;
      width_r    <= width_nxt;
      fmt_seen_r <= fmt_seen_nxt;
      pad_r      <= pad_nxt;
    end
  end

endmodule

// ===== rtl/wrp_out_reg.sv =====
module wrp_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 res_valid,
  input  wrp_pkg::wrp_result_t res,
  output logic                 advance,
  output logic                 out_valid,
  input  logic                 out_ready,
  output wrp_pkg::wrp_result_t out_res
);
  import wrp_pkg::*;

  logic        out_valid_r;
  logic        out_valid_nxt;
  wrp_result_t out_res_r;

  // The pipeline moves unless a result sits here untaken
  assign advance = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// ===== rtl/wav_riff_header_parser_core.sv =====
// RIFF/WAVE header parser. Feed the file one byte per request on the in_ channel
// (in_tuser high marks end of stream and carries no byte). The block checks the
// RIFF/WAVE header, walks the chunks, reads the fmt fields and gives at most one
// result per stream: at the data chunk, on a bad or unsupported header, or at
// an early end marker. After a result, bytes are dropped until the end marker,
// which rearms the parser. It takes one byte per cycle unless held back; a byte is
// registered, parsed once the result register can move, and any result it causes
// is registered and shows on out_tvalid. Input is held back only while the output
// register holds a result that out_tready has not taken.
module wav_riff_header_parser_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [wrp_pkg::IN_TDATA_W-1:0]     in_tdata,  // [7:0] data_byte
  input  logic                               in_tuser,  // [0] end_of_stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [1:0] status, [3:2] channel_count, [35:4] frame_rate,
  // [40:36] sample_bits, [72:41] data_length, [79:73] zero
  output logic [wrp_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import wrp_pkg::*;

  wrp_item_t   in_item;
  wrp_item_t   q_item;
  logic        q_valid;
  logic        advance;
  logic        res_valid;
  wrp_result_t res;
  wrp_result_t out_res;

  assign in_item.data_byte     = in_tdata;
  assign in_item.end_of_stream = in_tuser;

  // Input register
  wrp_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .advance  (advance),
    .q_valid  (q_valid),
    .q_item   (q_item)
  );

  // Header state machine
  wrp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (q_valid && advance),
    .item       (q_item),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Result register
  wrp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {7'd0, out_res.data_length, out_res.sample_bits,
                      out_res.frame_rate, out_res.channel_count, out_res.status};

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import wrp_pkg::*;

  localparam int STALL_LIMIT     = 4000;  // cycles with no request moving on either side
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 16;
  localparam int N_DIRECTED      = 28;

  typedef enum logic [2:0] {P_RIFF, P_HDR, P_FMT, P_SKIP, P_DONE} parse_phase_t;

  // One row of the directed table; has_want marks a status that is typed in
  typedef struct packed {
    logic [7:0] data;
    logic       eos;
    logic       has_want;
    logic [1:0] want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;

  // Parser image kept in step with the block
  parse_phase_t parse_phase = P_RIFF;
  logic [4:0]   byte_idx    = '0;
  logic [31:0]  chunk_id    = '0;
  logic [31:0]  chunk_len   = '0;
  logic [31:0]  skip_left   = '0;
  logic         magic_good  = 1'b1;
  logic [15:0]  fmt_code    = '0;
  logic [15:0]  fmt_chans   = '0;
  logic [31:0]  fmt_rate    = '0;
  logic [15:0]  fmt_width   = '0;
  logic         have_fmt    = 1'b0;
  logic         pad_left    = 1'b0;

  wrp_result_t pending_results[$];
  logic [7:0]  file_bytes[$];
  int          bytes_parsed = 0;
  int          results_predicted = 0;
  int          error_count = 0;
  int          idle_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic        hold_off_req = 1'b0;

  // Empty stream, bad RIFF magic, bytes and marker after a result,
  // then a clean header that ends between chunks
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{8'h00, 1'b1, 1'b1, ST_TRUNC},
    '{8'h52, 1'b0, 1'b0, ST_OK}, '{8'h49, 1'b0, 1'b0, ST_OK},
    '{8'h46, 1'b0, 1'b0, ST_OK}, '{8'h58, 1'b0, 1'b0, ST_OK},
    '{8'hFF, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK},
    '{8'hFF, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK},
    '{8'h57, 1'b0, 1'b0, ST_OK}, '{8'h41, 1'b0, 1'b0, ST_OK},
    '{8'h56, 1'b0, 1'b0, ST_OK}, '{8'h45, 1'b0, 1'b1, ST_INVALID},
    '{8'hFF, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b1, 1'b0, ST_OK},
    '{8'h52, 1'b0, 1'b0, ST_OK}, '{8'h49, 1'b0, 1'b0, ST_OK},
    '{8'h46, 1'b0, 1'b0, ST_OK}, '{8'h46, 1'b0, 1'b0, ST_OK},
    '{8'hFF, 1'b0, 1'b0, ST_OK}, '{8'hFF, 1'b0, 1'b0, ST_OK},
    '{8'hFF, 1'b0, 1'b0, ST_OK}, '{8'hFF, 1'b0, 1'b0, ST_OK},
    '{8'h57, 1'b0, 1'b0, ST_OK}, '{8'h41, 1'b0, 1'b0, ST_OK},
    '{8'h56, 1'b0, 1'b0, ST_OK}, '{8'h45, 1'b0, 1'b0, ST_OK},
    '{8'hAA, 1'b1, 1'b1, ST_INVALID}
  };

  wav_riff_header_parser_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [7:0] data_byte
    .in_tuser   (in_tuser),    // [0] end_of_stream
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)    // [1:0] status, [3:2] channels, [35:4] rate,
                               // [40:36] bits, [72:41] data length
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic logic [31:0] fmt_len();
    return (chunk_len < 32'd16) ? chunk_len : 32'd16;
  endfunction

  function automatic void go_skip();
    byte_idx    = '0;
    parse_phase = (skip_left == 0 && !pad_left) ? P_HDR : P_SKIP;
  endfunction

  // Close a fmt read; a non-PCM code ends the stream at once
  function automatic bit end_fmt(output wrp_result_t res);
    res = '0;
    if (fmt_code != FORMAT_PCM) begin
      res.status  = ST_UNSUP;
      parse_phase = P_DONE;
      return 1'b1;
    end
    have_fmt  = 1'b1;
    skip_left = chunk_len - fmt_len();
    pad_left  = chunk_len[0];
    go_skip();
    return 1'b0;
  endfunction

  // Advance the parser image by one request; returns 1 when a result is due
  function automatic bit parse_byte(input logic [7:0] data, input logic eos,
                                    output wrp_result_t res);
    logic [3:0] k;
    bit         fires;
    res = '0;
    if (eos) begin
      fires = (parse_phase != P_DONE);
      case (parse_phase)
        P_RIFF, P_FMT: res.status = ST_TRUNC;
        P_HDR:         res.status = (byte_idx == 0) ? ST_INVALID : ST_TRUNC;
        default:       res.status = ST_INVALID;
      endcase
      if (!fires) res = '0;
      // end marker always rearms
      parse_phase = P_RIFF;
      byte_idx    = '0;
      chunk_id    = '0;
      chunk_len   = '0;
      skip_left   = '0;
      magic_good  = 1'b1;
      fmt_code    = '0;
      fmt_chans   = '0;
      fmt_rate    = '0;
      fmt_width   = '0;
      have_fmt    = 1'b0;
      pad_left    = 1'b0;
      return fires;
    end
    case (parse_phase)
      P_RIFF: begin
        chunk_id = {chunk_id[23:0], data};
        if (byte_idx == 5'd3 && chunk_id != TAG_RIFF) magic_good = 1'b0;
        if (byte_idx == 5'd11) begin
          if (chunk_id != TAG_WAVE) magic_good = 1'b0;
          byte_idx = '0;
          chunk_id = '0;
          if (!magic_good) begin
            res.status  = ST_INVALID;
            parse_phase = P_DONE;
            return 1'b1;
          end
          parse_phase = P_HDR;
          return 1'b0;
        end
        byte_idx++;
        return 1'b0;
      end
      P_HDR: begin
        if (byte_idx < 5'd4) begin
          chunk_id = {chunk_id[23:0], data};
          if (byte_idx == 0) chunk_len = '0;
        end else begin
          chunk_len |= 32'(data) << (8 * (byte_idx - 5'd4));
        end
        if (byte_idx < 5'd7) begin
          byte_idx++;
          return 1'b0;
        end
        byte_idx = '0;
        if (chunk_id == TAG_FMT) begin
          fmt_code  = '0;
          fmt_chans = '0;
          fmt_rate  = '0;
          fmt_width = '0;
          if (fmt_len() == 0) return end_fmt(res);
          parse_phase = P_FMT;
          return 1'b0;
        end
        if (chunk_id == TAG_DATA) begin
          parse_phase = P_DONE;
          if (!have_fmt) begin
            res.status = ST_INVALID;
          end else if (fmt_rate == 0 || fmt_width != PCM_WIDTH ||
                       (fmt_chans != 16'd1 && fmt_chans != 16'd2)) begin
            res.status = ST_UNSUP;
          end else begin
            res.status        = ST_OK;
            res.channel_count = fmt_chans[1:0];
            res.frame_rate    = fmt_rate;
            res.sample_bits   = SAMPLE_BITS;
            res.data_length   = chunk_len;
          end
          return 1'b1;
        end
        skip_left = chunk_len;
        pad_left  = chunk_len[0];
        go_skip();
        return 1'b0;
      end
      P_FMT: begin
        k = byte_idx[3:0];
        if (k < 4'd2)       fmt_code  |= 16'(data) << (8 * k);
        else if (k < 4'd4)  fmt_chans |= 16'(data) << (8 * (k - 4'd2));
        else if (k < 4'd8)  fmt_rate  |= 32'(data) << (8 * (k - 4'd4));
        else if (k >= 4'd14) fmt_width |= 16'(data) << (8 * (k - 4'd14));
        byte_idx = {1'b0, k} + 5'd1;
        if (32'(byte_idx) >= fmt_len()) return end_fmt(res);
        return 1'b0;
      end
      P_SKIP: begin
        if (skip_left != 0) skip_left--;
        else pad_left = 1'b0;
        go_skip();
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string msg);
    if (error_count < 100) $display("%0t ns: mismatch: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] seen,
                             input logic [31:0] want);
    if (seen !== want)
      report_mismatch($sformatf("%s got %0h want %0h", name, seen, want));
  endtask

  // Compare every taken result with the oldest prediction
  always @(posedge clk) begin : result_check
    wrp_result_t seen;
    wrp_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen.status        = out_tdata[1:0];
      seen.channel_count = out_tdata[3:2];
      seen.frame_rate    = out_tdata[35:4];
      seen.sample_bits   = out_tdata[40:36];
      seen.data_length   = out_tdata[72:41];
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with none pending, status %0d", seen.status));
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(seen.status), 32'(want.status));
        check_field("channel_count", 32'(seen.channel_count), 32'(want.channel_count));
        check_field("frame_rate", seen.frame_rate, want.frame_rate);
        check_field("sample_bits", 32'(seen.sample_bits), 32'(want.sample_bits));
        check_field("data_length", seen.data_length, want.data_length);
      end
    end
  end

  // Watchdog: ends the run when requests stop moving on both sides
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Result side ready, with one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------- stimulus

  // Offer one request from a falling edge, predict it once it is taken
  task automatic send_item(input logic [7:0] data, input logic eos,
                           input logic has_want, input logic [1:0] want_status);
    wrp_result_t res;
    bit          got_one;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= eos;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (parse_phase != P_DONE || eos) bytes_parsed++;
    got_one = parse_byte(data, eos, res);
    if (has_want) begin
      res        = '0;
      res.status = want_status;
      got_one    = 1'b1;
    end
    if (got_one) begin
      pending_results.push_back(res);
      results_predicted++;
    end
    @(negedge clk);
  endtask

  // Tags go out first byte first, lengths little-endian
  function automatic void put_tag(input logic [31:0] tag);
    for (int i = 3; i >= 0; i--) file_bytes.push_back(tag[8*i +: 8]);
  endfunction

  function automatic void put_le32(input logic [31:0] v);
    for (int i = 0; i < 4; i++) file_bytes.push_back(v[8*i +: 8]);
  endfunction

  // fmt chunk, mostly usable PCM, sometimes short, long, odd or unusable
  function automatic void put_fmt_chunk();
    logic [31:0]  len;
    logic [15:0]  code;
    logic [15:0]  chans;
    logic [31:0]  rate;
    logic [15:0]  width;
    logic [127:0] body;
    case ($urandom_range(0, 9))
      0:       len = 32'd0;
      1:       len = $urandom_range(1, 15);
      2:       len = $urandom_range(17, 24);
      3:       len = 32'd18;
      default: len = 32'd16;
    endcase
    code = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : FORMAT_PCM;
    case ($urandom_range(0, 9))
      0:       chans = 16'($urandom());
      1:       chans = 16'd0;
      default: chans = 16'($urandom_range(1, 2));
    endcase
    case ($urandom_range(0, 15))
      0:       rate = 32'd0;
      1:       rate = 32'hFFFF_FFFF;
      default: rate = $urandom();
    endcase
    width = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 32)) : PCM_WIDTH;
    body  = {width, 16'($urandom()), 32'($urandom()), rate, chans, code};
    put_tag(TAG_FMT);
    put_le32(len);
    for (int i = 0; i < int'(len); i++)
      file_bytes.push_back((i < 16) ? body[8*i +: 8] : 8'($urandom()));
    if (len[0]) file_bytes.push_back(8'($urandom()));
  endfunction

  // Build one stream: mostly well-formed files, some empty, cut short, corrupted or noise
  function automatic void build_stream();
    int kind;
    int n;
    int pos;
    logic [31:0] len;
    file_bytes.delete();
    kind = $urandom_range(0, 19);
    if (kind == 0) return;
    if (kind <= 2) begin
      n = $urandom_range(1, 24);
      repeat (n) file_bytes.push_back(8'($urandom()));
      return;
    end
    put_tag(TAG_RIFF);
    put_le32($urandom());
    put_tag(TAG_WAVE);
    n = $urandom_range(0, 3);
    for (int c = 0; c < n; c++) begin
      if ($urandom_range(0, 2) == 0) begin
        put_fmt_chunk();
      end else begin
        // filler chunk tagged LIST or at random, with a short body
        len = $urandom_range(0, 6);
        put_tag(($urandom_range(0, 1) == 0) ? 32'h4C49_5354 : $urandom());
        put_le32(len);
        repeat (int'(len)) file_bytes.push_back(8'($urandom()));
        if (len[0]) file_bytes.push_back(8'($urandom()));
      end
    end
    if ($urandom_range(0, 9) != 0) put_fmt_chunk();
    put_tag(TAG_DATA);
    case ($urandom_range(0, 7))
      0:       put_le32(32'd0);
      1:       put_le32(32'hFFFF_FFFF);
      default: put_le32($urandom());
    endcase
    n = $urandom_range(0, 3);
    repeat (n) file_bytes.push_back(8'($urandom()));
    if (kind <= 5) begin
      pos = $urandom_range(0, file_bytes.size() - 1);
      while (file_bytes.size() > pos) void'(file_bytes.pop_back());
    end else if (kind <= 7) begin
      pos = $urandom_range(0, file_bytes.size() - 1);
      file_bytes[pos] = 8'($urandom());
    end
  endfunction

  // Random streams under one idling profile until enough bytes and results passed
  task automatic run_phase(input int s_pct, input int r_pct, input int n_items,
                           input int n_results);
    int items0;
    int res0;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    items0 = bytes_parsed;
    res0   = results_predicted;
    while (bytes_parsed - items0 < n_items || results_predicted - res0 < n_results) begin
      build_stream();
      foreach (file_bytes[i]) send_item(file_bytes[i], 1'b0, 1'b0, ST_OK);
      send_item(8'($urandom()), 1'b1, 1'b0, ST_OK);
      // occasional second marker, read as an empty stream
      if ($urandom_range(0, 9) == 0) send_item(8'($urandom()), 1'b1, 1'b0, ST_OK);
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    send_idle_pct = 25;
    recv_idle_pct = 57;
    foreach (directed_rows[i])
      send_item(directed_rows[i].data, directed_rows[i].eos,
                directed_rows[i].has_want, directed_rows[i].want);

    // random streams; the result side holds off once early on
    hold_off_req = 1'b1;
    run_phase(25, 57, 300, 16);
    run_phase(57, 25, 300, 16);
    run_phase(0, 0, 300, 16);
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
